[design/assert_macros.svh]
// Assertion macros shared by the ordered presence set RTL.
// No dependencies; each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[design/osp_pkg.sv]
// Package for the ordered presence set: field widths, operation codes,
// register indexes and the bitmap update struct. No dependencies.
`default_nettype none

package osp_pkg;

   // Field widths fixed by the interface.
   localparam int MODE_W    = 3;
   localparam int RANK_W    = 16;
   localparam int ELT_W     = 32;
   localparam int COUNT_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Offset of a rank from the first rank, one bit wider to hold a borrow or a carry.
   localparam int OFF_W = RANK_W + 1;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIND_MIN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND_NEXT = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_RANK    = 2'd1;

   // Presence bitmap update request for one item.
   typedef struct packed {
      logic set;
      logic clr;
      logic clear_all;
   } osp_upd_type;

endpackage

`default_nettype wire

[design/osp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module osp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port; a read at a written address returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/osp_bitmap.sv]
// Presence bitmap of the ordered presence set with its find-first search.
// Depends on osp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module osp_bitmap #(
   parameter int MAX_ELEMENTS = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire osp_pkg::osp_upd_type       upd,
   input  wire logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] upd_idx,
   input  wire logic [osp_pkg::OFF_W-1:0]  start,
   input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0] used_n,
   output logic                            find_hit,
   output logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] find_idx
);
   import osp_pkg::*;

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   logic [MAX_ELEMENTS-1:0] present_ff;
   logic [MAX_ELEMENTS-1:0] present_in;
   logic [MAX_ELEMENTS-1:0] window;
   logic [MAX_ELEMENTS-1:0] candidates;
   logic [MAX_ELEMENTS-1:0] lowest;

   // Presence update: clear all wins, then set or clear of one entry.
   always_comb begin
      present_in = present_ff;
      if (upd.clear_all) begin
         present_in = '0;
      end else if (upd.set) begin
         present_in[upd_idx] = 1'b1;
      end else if (upd.clr) begin
         present_in[upd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
   end

   // Search window: entries at or after the start index and below the used count.
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         window[i] = (OFF_W'(i) >= start) && (OFF_W'(i) < OFF_W'(used_n));
      end
   end

   // Isolate the lowest present entry in the window and encode its index.
   assign candidates = present_ff & window;
   assign lowest     = candidates & (~candidates + {{(MAX_ELEMENTS-1){1'b0}}, 1'b1});
   assign find_hit   = |candidates;

   always_comb begin
      find_idx = '0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         if (lowest[i]) begin
            find_idx = find_idx | IDX_W'(i);
         end
      end
   end

   // A clear-all request leaves no entry present.
   `ASSERT_NEXT(a_clear_all_empty, clock, reset, upd.clear_all, present_ff == '0)
   // A found entry always lies inside the used range.
   `ASSERT_IMPL(a_find_in_range, clock, reset, find_hit, 32'(find_idx) < 32'(used_n))
   // Set and clear of one entry never come from the same item.
   `ASSERT_IMPL(a_set_clr_excl, clock, reset, upd.set, !upd.clr)

endmodule

`default_nettype wire

[design/ordered_presence_set.sv]
// Ordered presence set top level: input register, bitmap stage, result register.
// Depends on osp_pkg, osp_ram, osp_bitmap and assert_macros.svh.
//
// Holds up to MAX_ELEMENTS ranked elements, each with a presence bit; entry i
// has rank first_rank + i. The block takes one item per clock cycle while the
// result side does not stall, and returns exactly one result per item. The item
// passes three registers: the input register, the middle stage that compares
// against the element RAM, updates the presence bitmap and priority-encodes the
// search window, and the result register that captures the element RAM read
// for a found entry. The one-per-cycle rate is carried by the single priority
// encode over the bitmap and a forward of the previous item's load into the
// insert and delete compare. Write the configuration registers only while no
// item is in flight. Presence is cleared at reset; the element table is not,
// and an entry reads as undefined until it has been loaded.
`default_nettype none
`include "assert_macros.svh"

module ordered_presence_set #(
   parameter int MAX_ELEMENTS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input item channel.
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [osp_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [osp_pkg::RANK_W-1:0]        req_rank,
   input  wire logic signed [osp_pkg::ELT_W-1:0]  req_elt_in,
   // Result item channel.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_ok,
   output logic                                   rsp_found,
   output logic signed [osp_pkg::ELT_W-1:0]       rsp_elt_out,
   output logic [osp_pkg::RANK_W-1:0]             rsp_rank_out,
   // Configuration write channel.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [osp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [osp_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import osp_pkg::*;

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int N_W   = $clog2(MAX_ELEMENTS + 1);

   // Configuration registers.
   logic [COUNT_W-1:0] count_ff;
   logic [RANK_W-1:0]  first_rank_ff;
   logic [N_W-1:0]     used_n;

   // Input register.
   logic               s1_valid_ff;
   logic [MODE_W-1:0]  s1_mode_ff;
   logic [RANK_W-1:0]  s1_rank_ff;
   logic [ELT_W-1:0]   s1_elt_ff;
   logic               s1_load;
   logic [OFF_W-1:0]   s1_off;
   logic               s1_below;
   logic               s1_hit;

   // Middle stage.
   logic               s2_valid_ff;
   logic [MODE_W-1:0]  s2_mode_ff;
   logic [ELT_W-1:0]   s2_elt_ff;
   logic [OFF_W-1:0]   s2_off_ff;
   logic               s2_below_ff;
   logic               s2_hit_ff;
   logic [IDX_W-1:0]   s2_idx;
   logic [ELT_W-1:0]   s2_stored;
   logic [ELT_W-1:0]   ram_a_data;
   logic               s2_eq;
   logic               s2_en;
   logic               s2_is_find;
   logic [OFF_W-1:0]   s2_start;
   logic               s2_ok;
   logic               s2_found;
   logic [RANK_W-1:0]  s2_rank_out;
   logic               ram_we;
   osp_upd_type        upd;
   logic               find_hit;
   logic [IDX_W-1:0]   find_idx;

   // Forward of the previous item's load into the compare.
   logic               fwd_valid_ff;
   logic [IDX_W-1:0]   fwd_idx_ff;
   logic [ELT_W-1:0]   fwd_data_ff;

   // Result register.
   logic               s3_valid_ff;
   logic               s3_ok_ff;
   logic               s3_found_ff;
   logic [RANK_W-1:0]  s3_rank_ff;
   logic [ELT_W-1:0]   ram_b_data;

   logic               advance;

   // Configuration writes; the port is always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         first_rank_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ELEMENT_COUNT: count_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_FIRST_RANK:    first_rank_ff <= csr_wdata[RANK_W-1:0];
            default: ;
         endcase
      end
   end

   // Number of entries in use, saturated to the table size.
   always_comb begin
      if (32'(count_ff) > MAX_ELEMENTS) begin
         used_n = N_W'(MAX_ELEMENTS);
      end else begin
         used_n = N_W'(count_ff);
      end
   end

   // The pipeline moves whenever the result register is free or being taken.
   assign advance   = !s3_valid_ff || !rsp_stall;
   assign s1_load   = advance || !s1_valid_ff;
   assign req_stall = s1_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_mode_ff <= req_mode;
         s1_rank_ff <= req_rank;
         s1_elt_ff  <= $unsigned(req_elt_in);
      end
   end

   // Locate the addressed entry from the rank.
   assign s1_off   = {1'b0, s1_rank_ff} - {1'b0, first_rank_ff};
   assign s1_below = s1_rank_ff < first_rank_ff;
   assign s1_hit   = !s1_below && (s1_off < OFF_W'(used_n));

   // Middle stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_elt_ff   <= s1_elt_ff;
         s2_off_ff   <= s1_off;
         s2_below_ff <= s1_below;
         s2_hit_ff   <= s1_hit;
      end
   end

   assign s2_idx = s2_off_ff[IDX_W-1:0];
   assign s2_en  = advance && s2_valid_ff;

   // Stored value for insert and delete, with the previous load forwarded.
   assign s2_stored = (fwd_valid_ff && (fwd_idx_ff == s2_idx)) ? fwd_data_ff : ram_a_data;
   assign s2_eq     = s2_stored == s2_elt_ff;

   // Record a load so the next item compares against the new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (advance) begin
         fwd_valid_ff <= ram_we;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_idx_ff  <= s2_idx;
         fwd_data_ff <= s2_elt_ff;
      end
   end

   // Element table writes and presence updates.
   assign ram_we        = s2_en && s2_hit_ff && (s2_mode_ff == MODE_LOAD);
   assign upd.set       = ram_we ||
                          (s2_en && s2_hit_ff && s2_eq && (s2_mode_ff == MODE_INSERT));
   assign upd.clr       = s2_en && s2_hit_ff && s2_eq && (s2_mode_ff == MODE_DELETE);
   assign upd.clear_all = s2_en && (s2_mode_ff == MODE_CLEAR);

   // Search start: entry zero for find minimum or a rank below the range, else the entry after the addressed one.
   assign s2_is_find = s2_mode_ff inside {MODE_FIND_MIN, MODE_FIND_NEXT};
   assign s2_start   = ((s2_mode_ff == MODE_FIND_MIN) || s2_below_ff) ? '0
                                                                      : s2_off_ff + OFF_W'(1);

   osp_bitmap #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .upd_idx (s2_idx),
      .start   (s2_start),
      .used_n  (used_n),
      .find_hit(find_hit),
      .find_idx(find_idx)
   );

   // Result fields of the middle stage.
   always_comb begin
      s2_ok       = 1'b0;
      s2_found    = 1'b0;
      s2_rank_out = '0;
      case (s2_mode_ff)
         MODE_LOAD:                   s2_ok = s2_hit_ff;
         MODE_INSERT, MODE_DELETE:    s2_ok = s2_hit_ff && s2_eq;
         MODE_FIND_MIN, MODE_FIND_NEXT: begin
            s2_found = find_hit;
            if (find_hit) begin
               s2_rank_out = first_rank_ff + RANK_W'(find_idx);
            end
         end
         default: ;
      endcase
   end

   // Element table copy read by the insert and delete compare.
   osp_ram #(
      .WIDTH(ELT_W),
      .DEPTH(MAX_ELEMENTS)
   ) u_ram_cmp (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(s2_idx),
      .wr_data(s2_elt_ff),
      .rd_en  (advance),
      .rd_addr(s1_off[IDX_W-1:0]),
      .rd_data(ram_a_data)
   );

   // Element table copy read for the found entry.
   osp_ram #(
      .WIDTH(ELT_W),
      .DEPTH(MAX_ELEMENTS)
   ) u_ram_find (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(s2_idx),
      .wr_data(s2_elt_ff),
      .rd_en  (advance && s2_is_find),
      .rd_addr(find_idx),
      .rd_data(ram_b_data)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ok_ff    <= s2_ok;
         s3_found_ff <= s2_found;
         s3_rank_ff  <= s2_rank_out;
      end
   end

   assign rsp_valid    = s3_valid_ff;
   assign rsp_ok       = s3_ok_ff;
   assign rsp_found    = s3_found_ff;
   assign rsp_rank_out = s3_rank_ff;
   assign rsp_elt_out  = s3_found_ff ? $signed(ram_b_data) : '0;

   // A result never reports both a completed update and a found entry.
   `ASSERT_IMPL(a_ok_found_excl, clock, reset, rsp_valid, !(rsp_ok && rsp_found))
   // Without a found entry the element and rank fields are zero.
   `ASSERT_IMPL(a_not_found_zero, clock, reset, rsp_valid && !rsp_found,
                (rsp_rank_out == '0) && (rsp_elt_out == '0))
   // The table is written only by an item that moves on to the result register.
   `ASSERT_NEXT(a_write_moves_on, clock, reset, ram_we, s3_valid_ff && s3_ok_ff)

endmodule

`default_nettype wire

[bench/tb_ordered_presence_set.sv]
// Self-checking bench for ordered_presence_set: random and directed set operations,
// checked against an in-bench model of the ranked table and presence bitmap.
// Depends on osp_pkg and the ordered_presence_set RTL only.
`default_nettype none

module tb_ordered_presence_set;
   import osp_pkg::*;

   localparam int SET_SIZE  = 64;
   localparam int RANK_MAX  = (1 << RANK_W) - 1;
   localparam int CYCLE_CAP = 200000;
   localparam int HOLD_LEN  = 60;

   // Modes and register indexes the block defines no function for.
   localparam logic [MODE_W-1:0]    MODE_UNUSED_A = 3'd6;
   localparam logic [MODE_W-1:0]    MODE_UNUSED_B = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B   = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [RANK_W-1:0]       rank;
      logic signed [ELT_W-1:0] elt;
   } set_op_type;

   typedef struct packed {
      logic                    ok;
      logic                    found;
      logic signed [ELT_W-1:0] elt_out;
      logic [RANK_W-1:0]       rank_out;
   } set_reply_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MODE_W-1:0]       req_mode = '0;
   logic [RANK_W-1:0]       req_rank = '0;
   logic signed [ELT_W-1:0] req_elt_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_ok;
   logic                    rsp_found;
   logic signed [ELT_W-1:0] rsp_elt_out;
   logic [RANK_W-1:0]       rsp_rank_out;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DAT_W-1:0]    csr_wdata = '0;

   ordered_presence_set #(.MAX_ELEMENTS(SET_SIZE)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_rank     (req_rank),
      .req_elt_in   (req_elt_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ok       (rsp_ok),
      .rsp_found    (rsp_found),
      .rsp_elt_out  (rsp_elt_out),
      .rsp_rank_out (rsp_rank_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Shadow of the block: element table, presence bits and both registers.
   logic signed [ELT_W-1:0] table_shadow [SET_SIZE];
   logic [SET_SIZE-1:0]     present_shadow = '0;
   logic [COUNT_W-1:0]      cfg_count = '0;
   logic [RANK_W-1:0]       cfg_first = '0;

   // Stimulus-side record of which entries hold a value, so that an insert or
   // a delete never compares against an entry that was never loaded.
   bit                      gen_loaded [SET_SIZE];
   logic signed [ELT_W-1:0] gen_val [SET_SIZE];

   set_op_type    pending_ops [$];
   set_reply_type reply_q [$];
   int         n_pushed = 0;
   int         n_accepted = 0;
   int         n_checked = 0;
   int         n_loads_ok = 0;
   int         n_hits = 0;
   int         n_rejects = 0;
   int         n_settings = 0;
   int         errors = 0;
   int         cycles = 0;
   bit         quiet = 1'b0;
   int         hold_token = 0;
   logic       req_taken = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Entries in use after saturation of the count register.
   function automatic int used_entries();
      return (int'(cfg_count) > SET_SIZE) ? SET_SIZE : int'(cfg_count);
   endfunction

   // Entries that a 16-bit rank can still address.
   function automatic int reachable_entries();
      int n;
      n = used_entries();
      return (n > RANK_MAX + 1 - int'(cfg_first)) ? RANK_MAX + 1 - int'(cfg_first) : n;
   endfunction

   // Applies one item to the shadow state and returns the reply it causes.
   function automatic set_reply_type apply_set_op(set_op_type op);
      set_reply_type r;
      int         n;
      int         idx;
      int         start;
      bit         hit;
      r = '0;
      n = used_entries();
      idx = int'(op.rank) - int'(cfg_first);
      hit = (idx >= 0) && (idx < n);
      case (op.mode)
         MODE_LOAD: begin
            if (hit) begin
               table_shadow[idx] = op.elt;
               present_shadow[idx] = 1'b1;
               r.ok = 1'b1;
            end
         end
         MODE_INSERT, MODE_DELETE: begin
            if (hit && table_shadow[idx] == op.elt) begin
               present_shadow[idx] = (op.mode == MODE_INSERT);
               r.ok = 1'b1;
            end
         end
         MODE_FIND_MIN, MODE_FIND_NEXT: begin
            start = (op.mode == MODE_FIND_MIN || idx < 0) ? 0 : idx + 1;
            for (int i = start; i < n && !r.found; i++) begin
               if (present_shadow[i]) begin
                  r.found = 1'b1;
                  r.elt_out = table_shadow[i];
                  r.rank_out = cfg_first + RANK_W'(i);
               end
            end
         end
         MODE_CLEAR: begin
            present_shadow = '0;
         end
         default: begin
         end
      endcase
      if (r.ok && op.mode == MODE_LOAD)
         n_loads_ok++;
      if (r.found)
         n_hits++;
      if (!r.ok && (op.mode == MODE_INSERT || op.mode == MODE_DELETE))
         n_rejects++;
      return r;
   endfunction

   // Queues an item for the driver and tracks which entries it loads.
   task automatic push_op(input logic [MODE_W-1:0] mode, input logic [RANK_W-1:0] rank,
                          input logic signed [ELT_W-1:0] elt);
      int idx;
      idx = int'(rank) - int'(cfg_first);
      if (mode == MODE_LOAD && idx >= 0 && idx < used_entries()) begin
         gen_loaded[idx] = 1'b1;
         gen_val[idx] = elt;
      end
      pending_ops.push_back('{mode: mode, rank: rank, elt: elt});
      n_pushed++;
   endtask

   function automatic logic signed [ELT_W-1:0] random_elt();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // A rank that addresses no entry in use: below the first rank or past the end.
   function automatic logic [RANK_W-1:0] outside_rank();
      int top;
      top = int'(cfg_first) + used_entries();
      if (cfg_first > 0 && (top > RANK_MAX || $urandom_range(0, 1) == 0))
         return RANK_W'($urandom_range(0, int'(cfg_first) - 1));
      return RANK_W'($urandom_range(top, RANK_MAX));
   endfunction

   // Mostly meaningful operations on loaded entries, with misses and noise mixed in.
   task automatic push_random_op();
      int                      reach;
      int                      pick;
      int                      idx;
      int                      c;
      logic [MODE_W-1:0]       mode;
      logic [RANK_W-1:0]       rank;
      logic signed [ELT_W-1:0] elt;
      reach = reachable_entries();
      pick = $urandom_range(0, 99);
      rank = RANK_W'($urandom);
      elt = random_elt();
      if (pick < 25) begin
         mode = MODE_LOAD;
         rank = (reach > 0 && $urandom_range(0, 9) != 0) ?
                cfg_first + RANK_W'($urandom_range(0, reach - 1)) : outside_rank();
      end else if (pick < 65) begin
         mode = (pick < 45) ? MODE_INSERT : MODE_DELETE;
         idx = -1;
         for (int t = 0; t < 8 && idx < 0 && reach > 0; t++) begin
            c = $urandom_range(0, reach - 1);
            if (gen_loaded[c])
               idx = c;
         end
         if (idx >= 0) begin
            rank = cfg_first + RANK_W'(idx);
            elt = ($urandom_range(0, 3) != 0) ? gen_val[idx] : gen_val[idx] ^ ($urandom | 1);
         end else begin
            rank = outside_rank();
         end
      end else if (pick < 77) begin
         mode = MODE_FIND_MIN;
      end else if (pick < 95) begin
         mode = MODE_FIND_NEXT;
         if (reach > 0 && $urandom_range(0, 9) < 7)
            rank = cfg_first + RANK_W'($urandom_range(0, reach - 1));
      end else if (pick < 97) begin
         mode = MODE_CLEAR;
      end else begin
         mode = $urandom_range(0, 1) ? MODE_UNUSED_A : MODE_UNUSED_B;
      end
      push_op(mode, rank, elt);
   endtask

   // Waits until every queued item is taken and every reply has come back.
   task automatic drain();
      while (n_accepted != n_pushed || reply_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write; the shadow copy follows at the handshake edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == CSR_ELEMENT_COUNT)
         cfg_count = data[COUNT_W-1:0];
      else if (idx == CSR_FIRST_RANK)
         cfg_first = data;
      n_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One register setting followed by random items, optionally with a long
   // result-side hold and a sender pause halfway through.
   task automatic run_phase(input logic [CSR_DAT_W-1:0] count_word,
                            input logic [CSR_DAT_W-1:0] first_word,
                            input int n_items, input bit with_hold, input bit with_pause);
      write_reg(CSR_ELEMENT_COUNT, count_word);
      write_reg(CSR_FIRST_RANK, first_word);
      for (int i = 0; i < n_items / 2; i++)
         push_random_op();
      if (with_hold)
         hold_token++;
      if (with_pause)
         drain();
      for (int i = n_items / 2; i < n_items; i++)
         push_random_op();
      drain();
   endtask

   // Item acceptance: each taken item is predicted at the edge that takes it.
   always @(posedge clock) begin : take_items
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         reply_q.push_back(apply_set_op('{mode: req_mode, rank: req_rank, elt: req_elt_in}));
         n_accepted++;
      end
   end

   // Driver: holds an item until taken, then offers the next after an optional gap.
   int gap_left = 0;
   always @(negedge clock) begin : drive_items
      set_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_ops.size() > 0) begin
         nxt = pending_ops.pop_front();
         req_mode <= nxt.mode;
         req_rank <= nxt.rank;
         req_elt_in <= nxt.elt;
         req_valid <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0)
            gap_left <= $urandom_range(1, 3);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result-side stall: short random bursts, plus a long hold on request.
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin : drive_rsp_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: every taken result is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      set_reply_type want;
      bit         bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_q.size() == 0) begin
            $error("result item arrived with no prediction pending");
            errors++;
         end else begin
            want = reply_q.pop_front();
            bad = 1'b0;
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0h, got %0h", want.ok, rsp_ok);
               bad = 1'b1;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0h, got %0h", want.found, rsp_found);
               bad = 1'b1;
            end
            if (rsp_elt_out !== want.elt_out) begin
               $error("elt_out: expected %0h, got %0h", want.elt_out, rsp_elt_out);
               bad = 1'b1;
            end
            if (rsp_rank_out !== want.rank_out) begin
               $error("rank_out: expected %0h, got %0h", want.rank_out, rsp_rank_out);
               bad = 1'b1;
            end
            if (bad)
               errors++;
            n_checked++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycles, reply_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a small window of eight entries starting at rank 100.
      write_reg(CSR_ELEMENT_COUNT, 16'd8);
      write_reg(CSR_FIRST_RANK, 16'd100);
      push_op(MODE_FIND_MIN, 16'd0, 32'sd0);            // empty set
      push_op(MODE_LOAD, 16'd100, 32'sh7FFF_FFFF);
      push_op(MODE_LOAD, 16'd107, 32'sh8000_0000);
      push_op(MODE_LOAD, 16'd99, 32'sd1);               // below the first rank
      push_op(MODE_LOAD, 16'd108, 32'sd2);              // past the last entry
      push_op(MODE_LOAD, 16'd103, -32'sd1);
      push_op(MODE_INSERT, 16'd103, -32'sd1);           // right behind its load
      push_op(MODE_LOAD, 16'd101, 32'sd0);
      push_op(MODE_FIND_MIN, 16'hFFFF, -32'sd1);
      push_op(MODE_FIND_NEXT, 16'd50, 32'sd0);          // search from entry 0
      push_op(MODE_FIND_NEXT, 16'd100, 32'sd0);
      push_op(MODE_FIND_NEXT, 16'd107, 32'sd0);         // nothing after the last
      push_op(MODE_FIND_NEXT, 16'hFFFF, 32'sd0);
      push_op(MODE_INSERT, 16'd103, 32'sd5);            // value mismatch
      push_op(MODE_DELETE, 16'd103, -32'sd1);
      push_op(MODE_DELETE, 16'd103, -32'sd1);
      push_op(MODE_FIND_NEXT, 16'd101, 32'sd0);
      push_op(MODE_INSERT, 16'd103, -32'sd1);
      push_op(MODE_DELETE, 16'd99, 32'sd0);
      push_op(MODE_INSERT, 16'd200, 32'sd0);
      push_op(MODE_UNUSED_A, 16'hFFFF, -32'sd1);
      push_op(MODE_UNUSED_B, 16'd0, 32'sd0);
      push_op(MODE_CLEAR, 16'd0, 32'sd0);
      push_op(MODE_FIND_MIN, 16'd0, 32'sd0);
      push_op(MODE_LOAD, 16'd104, 32'sd123);
      push_op(MODE_DELETE, 16'd104, 32'sd123);          // right behind its load
      drain();

      // Random phases across the register range; stale entries from one
      // setting show up through the finds of the next.
      run_phase(16'd64, 16'd0, 300, 1'b1, 1'b0);
      write_reg(CSR_SPARE_A, CSR_DAT_W'($urandom));
      write_reg(CSR_SPARE_B, CSR_DAT_W'($urandom));
      run_phase(CSR_DAT_W'(($urandom & 16'hFF80) | 16'd127), 16'd65500, 250, 1'b0, 1'b1);
      run_phase(16'd0, 16'hFFFF, 30, 1'b0, 1'b0);
      run_phase(16'd1, 16'hFFFF, 60, 1'b0, 1'b0);
      run_phase(CSR_DAT_W'($urandom_range(2, 63)), CSR_DAT_W'($urandom), 250, 1'b1, 1'b1);
      run_phase(16'd64, 16'hFFFF, 150, 1'b0, 1'b0);
      quiet = 1'b1;
      run_phase(16'd40, 16'd1000, 180, 1'b0, 1'b0);

      $display("Ran %0d items under %0d register writes; %0d results compared.",
               n_accepted, n_settings, n_checked);
      $display("Loads stored %0d, searches hit %0d, inserts and deletes refused %0d.",
               n_loads_ok, n_hits, n_rejects);
      if (errors == 0 && reply_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
